>>> rtl/core/stmc_pkg.sv
// Shared types and codes for the stepper trapezoid motion controller.
`timescale 1ns / 1ps

package stmc_pkg;

   typedef enum logic [2:0] {
      MOTION_IDLE     = 3'd0,
      MOTION_ACCEL    = 3'd1,
      MOTION_DECEL    = 3'd2,
      MOTION_CRUISE   = 3'd3,
      MOTION_SLOW     = 3'd4,
      MOTION_STOP     = 3'd5,
      MOTION_STOPZERO = 3'd6
   } motion_type;

   localparam logic [2:0] OP_MOVE      = 3'd0;
   localparam logic [2:0] OP_HOME_ZERO = 3'd1;
   localparam logic [2:0] OP_HOME_FAR  = 3'd2;
   localparam logic [2:0] OP_STOP      = 3'd3;
   localparam logic [2:0] OP_POLL      = 3'd4;
   localparam logic [2:0] OP_TICK      = 3'd5;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BUSY      = 3'd1;
   localparam logic [2:0] STATUS_ZERO_MOVE = 3'd2;
   localparam logic [2:0] STATUS_TOO_BIG   = 3'd3;
   localparam logic [2:0] STATUS_ON_SWITCH = 3'd4;

   localparam logic [2:0] CSR_MAX_STEPS   = 3'd0;
   localparam logic [2:0] CSR_RAMP_STEPS  = 3'd1;
   localparam logic [2:0] CSR_MICROSTEPS  = 3'd2;
   localparam logic [2:0] CSR_FAST_PERIOD = 3'd3;
   localparam logic [2:0] CSR_SLOW_PERIOD = 3'd4;
   localparam logic [2:0] CSR_PERIOD_STEP = 3'd5;
   localparam logic [2:0] CSR_REVERSE_DIR = 3'd6;

   localparam int CSR_DATA_WIDTH = 31;

endpackage

>>> rtl/core/stepper_trapezoid_motion_controller.sv
// Stepper motion controller with trapezoidal speed ramp, one event per word.
//
// Usage:
//  - req_* carries one event: move, home to zero or far switch, stop, poll
//    of the end switches, or a microstep timer tick. rsp_* returns one word
//    per event: status plus motion state, period, direction pin, drive
//    enable, position and steps remaining after the event.
//  - csr_* writes one configuration register per cycle (no read-back);
//    write only while no event is outstanding.
//  - The response is registered, valid the cycle after the event is accepted.
//    One event per clock unless a held response stalls it; the whole update is one
//    add/compare level on the controller state feeding the state registers.
//  - The response register is the only buffer: req_ready drops while a
//    response is held and rsp_ready is low, so nothing is lost or repeated.
//  - Reset: motor idle, position -1, period 0, configuration at its defaults
//    (no distance limit, ramp 1, 1 microstep, fast 2, slow 20, step 1).
`timescale 1ns / 1ps

module stepper_trapezoid_motion_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_opcode,
   input  logic signed [31:0]                 req_move_steps,
   input  logic                               req_switch_zero,
   input  logic                               req_switch_far,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [2:0]                         rsp_motion_state,
   output logic [15:0]                        rsp_period,
   output logic                               rsp_dir_pin,
   output logic                               rsp_drive_enable,
   output logic signed [31:0]                 rsp_position,
   output logic [30:0]                        rsp_remaining,
   input  logic                               csr_write,
   input  logic [2:0]                         csr_index,
   input  logic [stmc_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   import stmc_pkg::*;

   // configuration
   logic [30:0] max_steps_ff;
   logic [15:0] ramp_steps_ff;
   logic [8:0]  microsteps_ff;
   logic [15:0] fast_period_ff;
   logic [15:0] slow_period_ff;
   logic [15:0] period_step_ff;
   logic        reverse_dir_ff;

   // controller state
   motion_type  motion_ff, motion_in;
   logic        dir_neg_ff, dir_neg_in;
   logic [30:0] remaining_ff, remaining_in;
   logic [31:0] position_ff, position_in;
   logic [8:0]  ustep_ff, ustep_in;
   logic [15:0] period_ff, period_in;
   logic        dir_level_ff, dir_level_in;
   logic [2:0]  status_ff, status_in;
   logic        rsp_valid_ff;

   logic        accept;
   logic        cmd_neg;
   logic [31:0] cmd_mag;
   logic        cmd_start;
   logic [8:0]  ustep_next;
   logic [30:0] remaining_dec;
   logic [15:0] period_down;
   logic [15:0] period_up;
   logic [16:0] ramp_twice;
   motion_type  step_motion;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign ustep_next    = ustep_ff + 9'd1;
   assign remaining_dec = remaining_ff - 31'd1;
   assign period_down   = period_ff - period_step_ff;
   assign period_up     = period_ff + period_step_ff;
   assign ramp_twice    = {ramp_steps_ff, 1'b0};

   // magnitude and sign of a move or homing command
   always_comb begin
      case (req_opcode)
         OP_MOVE: begin
            cmd_neg = req_move_steps[31];
            cmd_mag = cmd_neg ? (32'd0 - req_move_steps) : req_move_steps;
         end
         OP_HOME_ZERO: begin
            cmd_neg = 1'b1;
            cmd_mag = {1'b0, max_steps_ff};
         end
         default: begin
            cmd_neg = 1'b0;
            cmd_mag = {1'b0, max_steps_ff};
         end
      endcase
   end

   always_comb begin
      motion_in    = motion_ff;
      dir_neg_in   = dir_neg_ff;
      remaining_in = remaining_ff;
      position_in  = position_ff;
      ustep_in     = ustep_ff;
      period_in    = period_ff;
      dir_level_in = dir_level_ff;
      status_in    = STATUS_OK;
      cmd_start    = 1'b0;
      step_motion  = motion_ff;

      case (req_opcode)
         OP_MOVE, OP_HOME_ZERO, OP_HOME_FAR: begin
            if (motion_ff != MOTION_IDLE) begin
               status_in = STATUS_BUSY;
            end else if (cmd_mag == 32'd0) begin
               status_in = STATUS_ZERO_MOVE;
            end else if (cmd_mag[31] ||
                         (max_steps_ff != 31'd0 && cmd_mag[30:0] > max_steps_ff)) begin
               status_in = STATUS_TOO_BIG;
            end else if ((cmd_neg && req_switch_zero) || (!cmd_neg && req_switch_far)) begin
               status_in = STATUS_ON_SWITCH;
            end else begin
               cmd_start = 1'b1;
            end
            if (cmd_start) begin
               dir_neg_in   = cmd_neg;
               dir_level_in = reverse_dir_ff ? !cmd_neg : cmd_neg;
               remaining_in = cmd_mag[30:0];
               period_in    = slow_period_ff;
               motion_in    = (cmd_mag < {15'd0, ramp_twice}) ? MOTION_SLOW : MOTION_ACCEL;
            end
         end
         OP_STOP: begin
            if (motion_ff != MOTION_IDLE) begin
               motion_in = MOTION_STOP;
            end
         end
         OP_POLL: begin
            if (motion_ff inside {MOTION_ACCEL, MOTION_DECEL, MOTION_CRUISE, MOTION_SLOW}) begin
               if (req_switch_zero && dir_neg_ff) begin
                  motion_in = MOTION_STOPZERO;
               end else if (req_switch_far && !dir_neg_ff) begin
                  motion_in = MOTION_STOP;
               end
            end
         end
         OP_TICK: begin
            if (motion_ff != MOTION_IDLE) begin
               if (ustep_next != microsteps_ff) begin
                  ustep_in = ustep_next;
               end else begin
                  // full step
                  ustep_in = 9'd0;
                  if (motion_ff == MOTION_STOPZERO) begin
                     position_in = 32'd0;
                  end else begin
                     remaining_in = remaining_dec;
                     if (remaining_dec == 31'd0) begin
                        step_motion = MOTION_STOP;
                     end
                     position_in = dir_neg_ff ? (position_ff - 32'd1) : (position_ff + 32'd1);
                  end
                  motion_in = step_motion;
                  case (step_motion)
                     MOTION_ACCEL: begin
                        if (period_down <= fast_period_ff || period_down > slow_period_ff) begin
                           period_in = fast_period_ff;
                           motion_in = MOTION_CRUISE;
                        end else begin
                           period_in = period_down;
                        end
                     end
                     MOTION_DECEL: begin
                        if (period_up >= slow_period_ff || period_up < fast_period_ff) begin
                           period_in = slow_period_ff;
                           motion_in = MOTION_SLOW;
                        end else begin
                           period_in = period_up;
                        end
                     end
                     MOTION_CRUISE: begin
                        if (remaining_in <= {15'd0, ramp_steps_ff}) begin
                           motion_in = MOTION_DECEL;
                        end
                     end
                     MOTION_SLOW: begin
                     end
                     default: begin
                        // stop states halt on this full step
                        ustep_in     = 9'd0;
                        remaining_in = 31'd0;
                        motion_in    = MOTION_IDLE;
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_steps_ff   <= 31'd0;
         ramp_steps_ff  <= 16'd1;
         microsteps_ff  <= 9'd1;
         fast_period_ff <= 16'd2;
         slow_period_ff <= 16'd20;
         period_step_ff <= 16'd1;
         reverse_dir_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAX_STEPS:   max_steps_ff   <= csr_data[30:0];
            CSR_RAMP_STEPS:  ramp_steps_ff  <= csr_data[15:0];
            CSR_MICROSTEPS:  microsteps_ff  <= csr_data[8:0];
            CSR_FAST_PERIOD: fast_period_ff <= csr_data[15:0];
            CSR_SLOW_PERIOD: slow_period_ff <= csr_data[15:0];
            CSR_PERIOD_STEP: period_step_ff <= csr_data[15:0];
            CSR_REVERSE_DIR: reverse_dir_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff    <= MOTION_IDLE;
         dir_neg_ff   <= 1'b0;
         remaining_ff <= 31'd0;
         position_ff  <= 32'hFFFF_FFFF;
         ustep_ff     <= 9'd0;
         period_ff    <= 16'd0;
         dir_level_ff <= 1'b0;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            motion_ff    <= motion_in;
            dir_neg_ff   <= dir_neg_in;
            remaining_ff <= remaining_in;
            position_ff  <= position_in;
            ustep_ff     <= ustep_in;
            period_ff    <= period_in;
            dir_level_ff <= dir_level_in;
            status_ff    <= status_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // state only moves on accept, so it doubles as the held response word
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_motion_state = motion_ff;
   assign rsp_period       = period_ff;
   assign rsp_dir_pin      = dir_level_ff;
   assign rsp_drive_enable = (motion_ff != MOTION_IDLE);
   assign rsp_position     = position_ff;
   assign rsp_remaining    = remaining_ff;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the stepper trapezoid motion controller.
`timescale 1ns / 1ps

module tb_top;
   import stmc_pkg::*;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam logic [2:0] CSR_SPARE  = 3'd7;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] steps;
      logic        sw_zero;
      logic        sw_far;
   } motion_cmd_type;

   typedef struct {
      logic [2:0]  status;
      logic [2:0]  motion;
      logic [15:0] period;
      logic        dir_pin;
      logic        drive_en;
      logic [31:0] position;
      logic [30:0] remaining;
   } ctrl_report_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [2:0]                req_opcode = OP_TICK;
   logic signed [31:0]        req_move_steps = '0;
   logic                      req_switch_zero = 1'b0;
   logic                      req_switch_far = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [2:0]                rsp_status;
   logic [2:0]                rsp_motion_state;
   logic [15:0]               rsp_period;
   logic                      rsp_dir_pin;
   logic                      rsp_drive_enable;
   logic signed [31:0]        rsp_position;
   logic [30:0]               rsp_remaining;
   logic                      csr_write = 1'b0;
   logic [2:0]                csr_index = CSR_MAX_STEPS;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   stepper_trapezoid_motion_controller DUT (.*);

   // settings as last written
   logic [30:0] lim_steps = '0;
   logic [15:0] ramp_len = 16'd1;
   logic [8:0]  ticks_per_step = 9'd1;
   logic [15:0] fast_per = 16'd2;
   logic [15:0] slow_per = 16'd20;
   logic [15:0] per_delta = 16'd1;
   logic        flip_dir = 1'b0;

   // predicted controller state
   motion_type  mot = MOTION_IDLE;
   int          heading = 0;
   logic [31:0] steps_due = '0;
   logic [31:0] pos_count = '1;
   logic [8:0]  ustep_count = '0;
   logic [15:0] cur_period = '0;
   logic        dir_level = 1'b0;

   motion_cmd_type  event_backlog[$];
   ctrl_report_type due_results[$];
   motion_cmd_type  sent_cmd;
   ctrl_report_type want;
   int planned = 0;
   int fault_count = 0;
   int word_count = 0;
   int send_gap = 0;
   int hold_left = 0;
   bit calm = 1'b0;
   bit maybe_moving = 1'b0;

   function automatic logic [2:0] launch_move(input logic neg, input logic [31:0] mag,
                                              input logic sw0, input logic swf);
      if (mot != MOTION_IDLE) return STATUS_BUSY;
      if (mag == 0) return STATUS_ZERO_MOVE;
      if (mag[31] || (lim_steps != 0 && mag > {1'b0, lim_steps})) return STATUS_TOO_BIG;
      if ((neg && sw0) || (!neg && swf)) return STATUS_ON_SWITCH;
      heading = neg ? -1 : 1;
      dir_level = neg ^ flip_dir;
      steps_due = mag;
      cur_period = slow_per;
      mot = (mag < {15'd0, ramp_len, 1'b0}) ? MOTION_SLOW : MOTION_ACCEL;
      return STATUS_OK;
   endfunction

   function automatic void take_tick();
      logic [8:0]  nxt;
      logic [15:0] val;
      if (mot == MOTION_IDLE) return;
      nxt = ustep_count + 9'd1;
      if (nxt != ticks_per_step) begin
         ustep_count = nxt;
         return;
      end
      ustep_count = '0;
      if (mot == MOTION_STOPZERO) begin
         pos_count = '0;
      end else begin
         steps_due = steps_due - 32'd1;
         if (steps_due == 0) mot = MOTION_STOP;
         if (heading > 0) pos_count = pos_count + 32'd1;
         else if (heading < 0) pos_count = pos_count - 32'd1;
      end
      case (mot)
         MOTION_ACCEL: begin
            val = cur_period - per_delta;
            // past either bound: clamp and leave the ramp
            if (val <= fast_per || val > slow_per) begin
               val = fast_per;
               mot = MOTION_CRUISE;
            end
            cur_period = val;
         end
         MOTION_DECEL: begin
            val = cur_period + per_delta;
            if (val >= slow_per || val < fast_per) begin
               val = slow_per;
               mot = MOTION_SLOW;
            end
            cur_period = val;
         end
         MOTION_CRUISE: begin
            if (steps_due <= {16'd0, ramp_len}) mot = MOTION_DECEL;
         end
         MOTION_SLOW: ;
         default: begin
            ustep_count = '0;
            heading = 0;
            steps_due = '0;
            mot = MOTION_IDLE;
         end
      endcase
   endfunction

   function automatic ctrl_report_type advance_controller(input motion_cmd_type cmd);
      ctrl_report_type rep;
      logic [2:0]      status;
      status = STATUS_OK;
      case (cmd.op)
         OP_MOVE: begin
            status = launch_move(cmd.steps[31], cmd.steps[31] ? 32'd0 - cmd.steps : cmd.steps,
                                 cmd.sw_zero, cmd.sw_far);
         end
         OP_HOME_ZERO: status = launch_move(1'b1, {1'b0, lim_steps}, cmd.sw_zero, cmd.sw_far);
         OP_HOME_FAR: status = launch_move(1'b0, {1'b0, lim_steps}, cmd.sw_zero, cmd.sw_far);
         OP_STOP: begin
            if (mot != MOTION_IDLE) mot = MOTION_STOP;
         end
         OP_POLL: begin
            if (mot == MOTION_ACCEL || mot == MOTION_DECEL || mot == MOTION_CRUISE ||
                mot == MOTION_SLOW) begin
               if (cmd.sw_zero && heading < 0) mot = MOTION_STOPZERO;
               else if (cmd.sw_far && heading > 0) mot = MOTION_STOP;
            end
         end
         OP_TICK: take_tick();
         default: ;
      endcase
      rep.status = status;
      rep.motion = mot;
      rep.period = cur_period;
      rep.dir_pin = dir_level;
      rep.drive_en = (mot != MOTION_IDLE);
      rep.position = pos_count;
      rep.remaining = steps_due[30:0];
      return rep;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [31:0] wild_steps();
      logic [31:0] mag;
      mag = $urandom_range(1, 20);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0001;
         4: return $urandom_range(0, 1) ? 32'd0 - mag : mag;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         if (fault_count < MAX_REPORTS)
            $display("word %0d %s mismatch: expected %0h, got %0h",
                     word_count, name, exp_val, act_val);
         fault_count++;
      end
   endtask

   task automatic queue_event(input logic [2:0] op, input logic [31:0] steps,
                              input logic sw0, input logic swf);
      motion_cmd_type cmd;
      cmd.op = op;
      cmd.steps = steps;
      cmd.sw_zero = sw0;
      cmd.sw_far = swf;
      event_backlog.push_back(cmd);
      planned++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_MAX_STEPS: lim_steps = val;
         CSR_RAMP_STEPS: ramp_len = val[15:0];
         CSR_MICROSTEPS: ticks_per_step = val[8:0];
         CSR_FAST_PERIOD: fast_per = val[15:0];
         CSR_SLOW_PERIOD: slow_per = val[15:0];
         CSR_PERIOD_STEP: per_delta = val[15:0];
         CSR_REVERSE_DIR: flip_dir = val[0];
         default: ;
      endcase
   endtask

   // unused upper data bits carry junk; the block keeps only the low bits
   task automatic apply_settings(input logic [30:0] lim, input logic [15:0] ramp,
                                 input logic [8:0] usteps, input logic [15:0] fast,
                                 input logic [15:0] slow, input logic [15:0] pstep,
                                 input logic rev);
      logic [30:0] junk;
      junk = 31'($urandom);
      write_reg(CSR_MAX_STEPS, lim);
      write_reg(CSR_RAMP_STEPS, {junk[14:0], ramp});
      write_reg(CSR_MICROSTEPS, {junk[21:0], usteps});
      write_reg(CSR_FAST_PERIOD, {junk[30:16], fast});
      write_reg(CSR_SLOW_PERIOD, {junk[29:15], slow});
      write_reg(CSR_PERIOD_STEP, {junk[28:14], pstep});
      write_reg(CSR_REVERSE_DIR, {junk[29:0], rev});
      write_reg(CSR_SPARE, 31'($urandom));
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic settle();
      while (event_backlog.size() != 0 || req_valid || due_results.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // moves and homing runs followed by the ticks they need, with polls, stops,
   // busy attempts and bursts of arbitrary words mixed in
   task automatic plan_phase(input int budget);
      int stop_mark, us, cap, mag_max, mag, n_ticks, r, home_poll;
      bit neg, blocked, homing, simple;
      logic [2:0] op;
      stop_mark = planned + budget;
      us = (ticks_per_step == 0) ? 512 : ticks_per_step;
      simple = (us > 50);
      cap = simple ? us + 3 : 200;
      while (planned < stop_mark) begin
         if (maybe_moving) begin
            queue_event(OP_STOP, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            repeat (us) queue_event(OP_TICK, $urandom, 1'b0, 1'b0);
            maybe_moving = 1'b0;
         end
         if (!simple && $urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 4))
               queue_event(3'($urandom_range(0, 7)), wild_steps(), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            maybe_moving = 1'b1;
         end else begin
            neg = 1'($urandom_range(0, 1));
            blocked = ($urandom_range(0, 9) == 0);
            homing = !simple && ($urandom_range(0, 9) < 3);
            mag_max = cap / us;
            if (lim_steps != 0 && lim_steps < mag_max) mag_max = lim_steps + 1;
            mag = homing ? lim_steps : $urandom_range(1, mag_max);
            if (homing) op = neg ? OP_HOME_ZERO : OP_HOME_FAR;
            else op = OP_MOVE;
            queue_event(op, homing ? $urandom : (neg ? -mag : mag),
                        neg ? blocked : 1'($urandom_range(0, 1)),
                        neg ? 1'($urandom_range(0, 1)) : blocked);
            if (blocked || mag == 0) n_ticks = 2;
            else if (mag > cap / us) n_ticks = cap;
            else n_ticks = mag * us + $urandom_range(0, 2);
            maybe_moving = !blocked && (mag > cap / us);
            home_poll = homing ? $urandom_range(0, n_ticks - 1) : -1;
            for (int i = 0; i < n_ticks; i++) begin
               if (i == home_poll) begin
                  // end switch reached: halt within one more full step
                  queue_event(OP_POLL, $urandom, neg, !neg);
                  n_ticks = i + us;
                  maybe_moving = 1'b0;
               end
               r = $urandom_range(0, 59);
               if (r == 0) begin
                  queue_event(OP_STOP, $urandom, 1'b0, 1'b0);
               end else if (r == 1) begin
                  queue_event(OP_MOVE, $urandom_range(1, 9), 1'b0, 1'b0);
                  maybe_moving = 1'b1;
               end else if (r < 6) begin
                  queue_event(OP_POLL, $urandom, $urandom_range(0, 3) == 0,
                              $urandom_range(0, 3) == 0);
               end
               queue_event(OP_TICK, $urandom, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // driver: one word per handshake, random gaps between words
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) due_results.push_back(advance_controller(sent_cmd));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (event_backlog.size() > 0) begin
               sent_cmd = event_backlog.pop_front();
               req_valid <= 1'b1;
               req_opcode <= sent_cmd.op;
               req_move_steps <= sent_cmd.steps;
               req_switch_zero <= sent_cmd.sw_zero;
               req_switch_far <= sent_cmd.sw_far;
               send_gap = idle_span();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure, compares each word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            word_count++;
            if (due_results.size() == 0) begin
               if (fault_count < MAX_REPORTS)
                  $display("word %0d arrived with nothing predicted", word_count);
               fault_count++;
            end else begin
               want = due_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("motion_state", 32'(want.motion), 32'(rsp_motion_state));
               check_field("period", 32'(want.period), 32'(rsp_period));
               check_field("dir_pin", 32'(want.dir_pin), 32'(rsp_dir_pin));
               check_field("drive_enable", 32'(want.drive_en), 32'(rsp_drive_enable));
               check_field("position", want.position, rsp_position);
               check_field("remaining", 32'(want.remaining), 32'(rsp_remaining));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            hold_left = idle_span();
            rsp_ready <= (hold_left == 0);
         end
      end
   end

   initial begin
      int          phase;
      logic [30:0] lim_pick;
      logic [15:0] fast_pick;
      logic [15:0] slow_pick;
      logic [15:0] step_pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no limit, ramp 1, one tick per step, fast 2, slow 20
      queue_event(OP_TICK, 32'd0, 1'b0, 1'b0);
      queue_event(OP_STOP, 32'd0, 1'b0, 1'b0);
      queue_event(OP_POLL, 32'd0, 1'b1, 1'b1);
      queue_event(OP_SPARE_A, 32'hFFFF_FFFF, 1'b1, 1'b1);
      queue_event(OP_SPARE_B, 32'h1234_5678, 1'b0, 1'b1);
      queue_event(OP_MOVE, 32'd0, 1'b0, 1'b0);
      queue_event(OP_HOME_ZERO, 32'd0, 1'b0, 1'b0);
      queue_event(OP_HOME_FAR, 32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_event(OP_MOVE, 32'h8000_0000, 1'b0, 1'b0);
      queue_event(OP_MOVE, -32'sd5, 1'b1, 1'b0);
      queue_event(OP_MOVE, 32'd5, 1'b0, 1'b1);
      queue_event(OP_MOVE, 32'd3, 1'b1, 1'b0);
      repeat (3) queue_event(OP_TICK, 32'd0, 1'b0, 1'b0);
      queue_event(OP_MOVE, 32'h7FFF_FFFF, 1'b0, 1'b0);
      queue_event(OP_MOVE, 32'd1, 1'b0, 1'b0);
      repeat (2) queue_event(OP_TICK, 32'd0, 1'b0, 1'b0);
      queue_event(OP_STOP, 32'd0, 1'b0, 1'b0);
      queue_event(OP_TICK, 32'd0, 1'b0, 1'b0);
      queue_event(OP_MOVE, 32'h8000_0001, 1'b0, 1'b1);
      queue_event(OP_TICK, 32'd0, 1'b0, 1'b0);
      queue_event(OP_POLL, 32'd0, 1'b1, 1'b0);
      queue_event(OP_TICK, 32'd0, 1'b0, 1'b0);
      queue_event(OP_MOVE, 32'd2, 1'b0, 1'b0);
      queue_event(OP_POLL, 32'd0, 1'b0, 1'b1);
      queue_event(OP_TICK, 32'd0, 1'b0, 1'b0);
      settle();

      // every setting at its top value, but microsteps at 256
      apply_settings(31'h7FFF_FFFF, 16'hFFFF, 9'd256, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      plan_phase(20);
      settle();
      // zero microsteps: a full step only after the counter wraps
      calm = 1'b1;
      apply_settings(31'd12, 16'd1, 9'd0, 16'd2, 16'd20, 16'd1, 1'b0);
      plan_phase(20);
      settle();
      // period step wraps past zero
      calm = 1'b0;
      apply_settings(31'd30, 16'd3, 9'd1, 16'd2, 16'hFFFF, 16'hFFFF, 1'b0);
      plan_phase(40);
      settle();
      // fast bound above slow bound
      apply_settings(31'd25, 16'd2, 9'd2, 16'd100, 16'd10, 16'd3, 1'b1);
      plan_phase(40);
      settle();
      // smallest values
      calm = 1'b1;
      apply_settings(31'd1, 16'd1, 9'd1, 16'd2, 16'd2, 16'd1, 1'b0);
      plan_phase(40);
      settle();
      calm = 1'b0;
      apply_settings(31'd40, 16'd4, 9'd3, 16'd5, 16'd60, 16'd7, 1'b1);
      plan_phase(40);
      settle();

      for (phase = 0; phase < 2; phase++) begin
         calm = (phase % 3 == 1);
         case ($urandom_range(0, 3))
            0: lim_pick = '0;
            1: lim_pick = 31'($urandom_range(1, 8));
            2: lim_pick = 31'($urandom_range(9, 60));
            default: lim_pick = 31'h7FFF_FFFF;
         endcase
         fast_pick = 16'($urandom_range(2, 30));
         if ($urandom_range(0, 5) == 0) slow_pick = 16'($urandom_range(2, fast_pick));
         else slow_pick = fast_pick + 16'($urandom_range(0, 40));
         if ($urandom_range(0, 7) == 0) step_pick = 16'($urandom_range(1000, 65535));
         else step_pick = 16'($urandom_range(1, 6));
         apply_settings(lim_pick, 16'($urandom_range(1, 10)), 9'($urandom_range(1, 4)),
                        fast_pick, slow_pick, step_pick, 1'($urandom_range(0, 1)));
         plan_phase(45);
         settle();
      end

      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
